// ===== design/rwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_pkg: shared types and constants of the replay window table
// Table geometry, status codes, register indexes and the entry / request
// records passed between the sequencer, compare unit and entry store.
// ----------------------------------------------------------------------------
package rwt_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int NODE_W = 8;
   localparam int EP_W   = 16;
   localparam int SESS_W = 32;
   localparam int CMD_W  = 32;
   localparam int STAT_W = 3;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_BROADCAST_NODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STATIC_EP_LIM  = CSR_IDX_W'(1);

   localparam logic [NODE_W-1:0] BROADCAST_RESET = NODE_W'(255);
   localparam logic [EP_W-1:0]   EP_LIMIT_RESET  = EP_W'(256);

   localparam logic MODE_ACCEPT = 1'b0;
   localparam logic MODE_ROTATE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
   localparam logic [STAT_W-1:0] ST_BAD_ARG   = STAT_W'(1);
   localparam logic [STAT_W-1:0] ST_MISMATCH  = STAT_W'(2);
   localparam logic [STAT_W-1:0] ST_REPLAY    = STAT_W'(3);
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = STAT_W'(4);
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = STAT_W'(5);

   typedef struct packed {
      logic              valid;
      logic              has_cmd;
      logic [NODE_W-1:0] node;
      logic [EP_W-1:0]   endpoint;
      logic [SESS_W-1:0] session;
      logic [CMD_W-1:0]  last_cmd;
   } entry_type;

   typedef struct packed {
      logic              mode;
      logic [NODE_W-1:0] node;
      logic [EP_W-1:0]   endpoint;
      logic [SESS_W-1:0] session;
      logic [SESS_W-1:0] new_session;
      logic [CMD_W-1:0]  command;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] broadcast_node;
      logic [EP_W-1:0]   ep_limit;
   } cfg_type;

   typedef struct packed {
      logic key_hit;
      logic sess_eq;
      logic newer;
   } cmp_type;

endpackage

// ===== design/rwt_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_cmp: entry compare unit
// Key match, session match and serial-number newer test of one entry
// against the current request; reused on every scan step.
// ----------------------------------------------------------------------------
module rwt_cmp (
   input  rwt_pkg::entry_type entry,
   input  rwt_pkg::req_type   req,
   output rwt_pkg::cmp_type   result
);

   logic [rwt_pkg::CMD_W-1:0] diff;

   assign diff = req.command - entry.last_cmd;

   always_comb begin
      result.key_hit = entry.valid && (entry.node == req.node)
                       && (entry.endpoint == req.endpoint);
      result.sess_eq = (entry.session == req.session);
      // newer when no command is recorded yet, or when the difference is nonzero and in the lower half of the space
      result.newer   = !entry.has_cmd
                       || ((diff != '0) && !diff[rwt_pkg::CMD_W-1]);
   end

endmodule

// ===== design/rwt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_table: replay entry store
// One read index, one write port of a whole entry. Valid bits clear on
// reset; entry contents are only looked at while valid.
// ----------------------------------------------------------------------------
module rwt_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rwt_pkg::IDX_W-1:0]    rd_idx,
   output rwt_pkg::entry_type           rd_entry,
   input  logic                         wr_en,
   input  logic [rwt_pkg::IDX_W-1:0]    wr_idx,
   input  rwt_pkg::entry_type           wr_entry
);

   logic [rwt_pkg::TABLE_DEPTH-1:0]  valid_ff;
   logic [rwt_pkg::TABLE_DEPTH-1:0]  valid_in;
   rwt_pkg::entry_type               data_ff [rwt_pkg::TABLE_DEPTH];

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = wr_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_ff[wr_idx] <= wr_entry;
      end
   end

   always_comb begin
      rd_entry       = data_ff[rd_idx];
      rd_entry.valid = valid_ff[rd_idx];
   end

endmodule

// ===== design/rwt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_seq: lookup sequencer
// Latches a request, walks the table one entry a cycle through the shared
// compare unit, updates the chosen entry and loads the response register.
// ----------------------------------------------------------------------------
module rwt_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  rwt_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rwt_pkg::req_type               req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rwt_pkg::STAT_W-1:0]     rsp_status,
   output logic [rwt_pkg::IDX_W-1:0]      rd_idx,
   input  rwt_pkg::entry_type             rd_entry,
   output logic                           wr_en,
   output logic [rwt_pkg::IDX_W-1:0]      wr_idx,
   output rwt_pkg::entry_type             wr_entry
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   localparam logic [rwt_pkg::IDX_W-1:0] LAST_IDX = rwt_pkg::IDX_W'(rwt_pkg::TABLE_DEPTH - 1);

   state_type                       state_ff, state_in;
   rwt_pkg::req_type                req_ff, req_in;
   logic                            bad_ff, bad_in;
   logic [rwt_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                            free_found_ff, free_found_in;
   logic [rwt_pkg::IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [rwt_pkg::STAT_W-1:0]      hold_ff, hold_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rwt_pkg::STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   rwt_pkg::cmp_type                cmp;
   logic                            bad_arg;

   rwt_cmp u_cmp (
      .entry  (rd_entry),
      .req    (req_ff),
      .result (cmp)
   );

   always_comb begin
      bad_arg = (req.node == cfg.broadcast_node) || (req.endpoint >= cfg.ep_limit);
      if (req.mode == rwt_pkg::MODE_ROTATE) begin
         bad_arg = bad_arg || (req.new_session == '0) || (req.new_session == req.session);
      end else begin
         bad_arg = bad_arg || (req.command == '0);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      bad_in        = bad_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_entry      = rd_entry;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req;
               bad_in        = bad_arg;
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (bad_ff) begin
               hold_in  = rwt_pkg::ST_BAD_ARG;
               state_in = S_RESP;
            end else if (cmp.key_hit) begin
               state_in = S_RESP;
               if (!cmp.sess_eq) begin
                  hold_in = rwt_pkg::ST_MISMATCH;
               end else if (req_ff.mode == rwt_pkg::MODE_ROTATE) begin
                  hold_in           = rwt_pkg::ST_OK;
                  wr_en             = 1'b1;
                  wr_entry.session  = req_ff.new_session;
                  wr_entry.has_cmd  = 1'b0;
                  wr_entry.last_cmd = '0;
               end else if (!cmp.newer) begin
                  hold_in = rwt_pkg::ST_REPLAY;
               end else begin
                  hold_in           = rwt_pkg::ST_OK;
                  wr_en             = 1'b1;
                  wr_entry.has_cmd  = 1'b1;
                  wr_entry.last_cmd = req_ff.command;
               end
            end else begin
               if (!rd_entry.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_RESP;
                  if (req_ff.mode == rwt_pkg::MODE_ROTATE) begin
                     hold_in = rwt_pkg::ST_NOT_FOUND;
                  end else if (free_found_ff || !rd_entry.valid) begin
                     hold_in           = rwt_pkg::ST_OK;
                     wr_en             = 1'b1;
                     wr_idx            = free_found_ff ? free_idx_ff : idx_ff;
                     wr_entry.valid    = 1'b1;
                     wr_entry.has_cmd  = 1'b1;
                     wr_entry.node     = req_ff.node;
                     wr_entry.endpoint = req_ff.endpoint;
                     wr_entry.session  = req_ff.session;
                     wr_entry.last_cmd = req_ff.command;
                  end else begin
                     hold_in = rwt_pkg::ST_NO_SPACE;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hold_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      bad_ff        <= bad_in;
      idx_ff        <= idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rd_idx     = idx_ff;

endmodule

// ===== design/replay_window_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_window_table: anti-replay sequence table
// Keyed table of (node, endpoint) entries with session and last command
// number; checks accept and rotate requests, one status word per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tdata 120b, tuser = mode
//  rsp_     out  rsp_tvalid/tready     tdata 8b (status)
//  csr_     in   csr_valid/csr_ready   csr_index, csr_data
//
//  From accept to response, the sequencer reads one entry a cycle through a
//  single compare unit and stops at the first key hit; a bad argument ends
//  the scan at its first step. req_tready is low meanwhile.
//  The response register holds a word while rsp_tready is low; the next
//  request is taken meanwhile and waits in its final step for the slot.
//  Synchronous reset empties the table and restores the state, response valid and CSR registers.
// ----------------------------------------------------------------------------
module replay_window_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // source_node[7:0], endpoint_id[23:8], cur_session[55:24],
   // new_session[87:56], command_number[119:88]
   input  logic [rwt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], zero fill [7:3]
   output logic [rwt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rwt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rwt_pkg::CSR_DATA_W-1:0]    csr_data
);

   rwt_pkg::cfg_type               cfg_ff, cfg_in;
   rwt_pkg::req_type               req;
   rwt_pkg::entry_type             rd_entry;
   rwt_pkg::entry_type             wr_entry;
   logic [rwt_pkg::IDX_W-1:0]      rd_idx;
   logic [rwt_pkg::IDX_W-1:0]      wr_idx;
   logic                           wr_en;
   logic [rwt_pkg::STAT_W-1:0]     status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rwt_pkg::REG_BROADCAST_NODE: cfg_in.broadcast_node = csr_data[rwt_pkg::NODE_W-1:0];
            rwt_pkg::REG_STATIC_EP_LIM:  cfg_in.ep_limit       = csr_data[rwt_pkg::EP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.broadcast_node <= rwt_pkg::BROADCAST_RESET;
         cfg_ff.ep_limit       <= rwt_pkg::EP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req.mode        = req_tuser;
      req.node        = req_tdata[7:0];
      req.endpoint    = req_tdata[23:8];
      req.session     = req_tdata[55:24];
      req.new_session = req_tdata[87:56];
      req.command     = req_tdata[119:88];
   end

   rwt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry)
   );

   rwt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rd_idx     (rd_idx),
      .rd_entry   (rd_entry),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_entry   (wr_entry)
   );

   assign rsp_tdata = {{(rwt_pkg::RSP_DATA_W - rwt_pkg::STAT_W){1'b0}}, status};

endmodule

// ===== design/rwt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwt_checker: port-level checks of the replay window table
// Response hold, status range, one request in flight, reset behaviour.
// ----------------------------------------------------------------------------
module rwt_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [rwt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd6) && (rsp_tdata[2:0] != 3'd7)
                     && (rsp_tdata[rwt_pkg::RSP_DATA_W-1:rwt_pkg::STAT_W] == '0))
      else $error("undefined status code");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while another is in progress");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind replay_window_table rwt_checker u_rwt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
